// ===== hw/rtl/ddcm_pkg.sv =====
// Shared types, widths and constants of the debounced duty-cycle meter.
package ddcm_pkg;

  localparam int AVG_WINDOW = 240;
  localparam int IDX_W      = $clog2(AVG_WINDOW);
  localparam int CNT_W      = $clog2(AVG_WINDOW + 1);
  localparam int DUTY_W     = 7;
  localparam int DUTY_MAX   = 100;
  localparam int SUM_W      = $clog2(DUTY_MAX * AVG_WINDOW + 1);
  localparam int TIME_W     = 32;
  localparam int ELAPSED_W  = 16;
  localparam int DEB_W      = 16;
  localparam logic [DEB_W-1:0] DEB_RESET = DEB_W'(100);
  localparam int DIV_STEPS  = DUTY_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);
  localparam int NUM_W      = TIME_W + DIV_STEPS;
  localparam int DS_W       = TIME_W + DIV_STEPS - 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SAMPLE,
    S_PREP,
    S_DIV_DUTY,
    S_PUSH,
    S_AVG_LOAD,
    S_DIV_AVG,
    S_AVG_SAVE,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic sample;
    logic prep;
    logic div_step;
    logic push;
    logic avg_load;
    logic avg_save;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic action;
  } dp_status_t;

endpackage

// ===== hw/rtl/ddcm_ifs.sv =====
// Channel interfaces: input words, result words and the configuration write.
interface ddcm_in_if import ddcm_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic                 raw_level;
  logic [ELAPSED_W-1:0] elapsed_ms;

  modport source (output valid, output action, output raw_level, output elapsed_ms,
                  input ready);
  modport sink   (input valid, input action, input raw_level, input elapsed_ms,
                  output ready);
endinterface

interface ddcm_out_if import ddcm_pkg::*;;
  logic              valid;
  logic              ready;
  logic              compressor_on;
  logic [TIME_W-1:0] cycle_total;
  logic [DUTY_W-1:0] window_duty;
  logic [DUTY_W-1:0] average_duty;
  logic              window_closed;

  modport source (output valid, output compressor_on, output cycle_total,
                  output window_duty, output average_duty, output window_closed,
                  input ready);
  modport sink   (input valid, input compressor_on, input cycle_total,
                  input window_duty, input average_duty, input window_closed,
                  output ready);
endinterface

interface ddcm_cfg_if import ddcm_pkg::*;;
  logic             valid;
  logic             ready;
  logic [DEB_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/ddcm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ddcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/ddcm_ctrl.sv =====
// Controller: sequences sampling, the shared divider, the ring update and the result.
module ddcm_ctrl import ddcm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready
);

  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic              last_step;

  assign last_step = (step == STEP_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_SAMPLE;
        end
      end
      S_SAMPLE: begin
        cmd.sample = 1'b1;
        state_next = status.action ? S_PREP : S_OUT;
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        step_next  = '0;
        state_next = S_DIV_DUTY;
      end
      S_DIV_DUTY: begin
        cmd.div_step = 1'b1;
        step_next    = step + STEP_W'(1);
        if (last_step) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push   = 1'b1;
        state_next = S_AVG_LOAD;
      end
      S_AVG_LOAD: begin
        cmd.avg_load = 1'b1;
        step_next    = '0;
        state_next   = S_DIV_AVG;
      end
      S_DIV_AVG: begin
        cmd.div_step = 1'b1;
        step_next    = step + STEP_W'(1);
        if (last_step) begin
          state_next = S_AVG_SAVE;
        end
      end
      S_AVG_SAVE: begin
        cmd.avg_save = 1'b1;
        state_next   = S_OUT;
      end
      S_OUT: begin
        // The result register is free once the previous word has been taken.
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/ddcm_dp.sv =====
// Datapath: time and debounce state, duty ring, running sum, shared divider, result register.
module ddcm_dp import ddcm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  input  logic                 in_action,
  input  logic                 in_raw_level,
  input  logic [ELAPSED_W-1:0] in_elapsed_ms,
  input  logic                 cfg_we,
  input  logic [DEB_W-1:0]     cfg_data,
  output logic                 compressor_on,
  output logic [TIME_W-1:0]    cycle_total,
  output logic [DUTY_W-1:0]    window_duty,
  output logic [DUTY_W-1:0]    average_duty,
  output logic                 window_closed
);

  logic [DEB_W-1:0]     settle_ms;
  logic [TIME_W-1:0]    time_now;
  logic                 last_raw;
  logic [TIME_W-1:0]    last_change_time;
  logic                 deb_state;
  logic [TIME_W-1:0]    on_time_accum;
  logic [TIME_W-1:0]    window_start;
  logic [TIME_W-1:0]    cycle_counter;
  logic [DUTY_W-1:0]    last_duty;
  logic [SUM_W-1:0]     duty_sum;
  logic [CNT_W-1:0]     entry_count;
  logic [IDX_W-1:0]     write_index;
  logic [DUTY_W-1:0]    avg_duty;

  logic                 action_r;
  logic                 raw_r;
  logic [ELAPSED_W-1:0] elapsed_r;

  logic [NUM_W-1:0]     div_rem;
  logic [DS_W-1:0]      div_ds;
  logic [DUTY_W-1:0]    div_q;
  logic                 sat;

  logic [TIME_W-1:0]    now;
  logic                 raw_chg;
  logic                 stable;
  logic                 deb_new;
  logic [TIME_W-1:0]    span;
  logic [TIME_W-1:0]    span_nz;
  logic                 div_ge;
  logic [DUTY_W-1:0]    duty;
  logic                 full;
  logic [DUTY_W-1:0]    old_duty;

  assign status.action = action_r;

  // A level change restarts the stable interval, so it can never qualify in the same item.
  assign now     = time_now + TIME_W'(elapsed_r);
  assign raw_chg = (raw_r != last_raw);
  assign stable  = !raw_chg && ((now - last_change_time) > TIME_W'(settle_ms));
  assign deb_new = stable ? raw_r : deb_state;

  assign span    = time_now - window_start;
  assign span_nz = (span == '0) ? TIME_W'(1) : span;
  assign div_ge  = (div_rem >= NUM_W'(div_ds));
  assign duty    = sat ? DUTY_W'(DUTY_MAX) : div_q;
  assign full    = (entry_count == CNT_W'(AVG_WINDOW));

  ddcm_ram #(
    .WIDTH (DUTY_W),
    .DEPTH (AVG_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (write_index),
    .wdata (duty),
    .re    (cmd.prep),
    .raddr (write_index),
    .rdata (old_duty)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_ms        <= DEB_RESET;
      time_now         <= '0;
      last_raw         <= 1'b1;
      last_change_time <= '0;
      deb_state        <= 1'b0;
      on_time_accum    <= '0;
      window_start     <= '0;
      cycle_counter    <= '0;
      last_duty        <= '0;
      duty_sum         <= '0;
      entry_count      <= '0;
      write_index      <= '0;
      avg_duty         <= '0;
    end else begin
      if (cfg_we) begin
        settle_ms <= cfg_data;
      end
      if (cmd.sample) begin
        time_now <= now;
        if (raw_chg) begin
          last_change_time <= now;
          last_raw         <= raw_r;
        end
        deb_state <= deb_new;
        if (deb_new && !deb_state) begin
          cycle_counter <= cycle_counter + TIME_W'(1);
        end
        if (deb_new) begin
          on_time_accum <= on_time_accum + TIME_W'(elapsed_r);
        end
      end
      if (cmd.push) begin
        last_duty <= duty;
        if (full) begin
          duty_sum <= duty_sum - SUM_W'(old_duty) + SUM_W'(duty);
        end else begin
          duty_sum    <= duty_sum + SUM_W'(duty);
          entry_count <= entry_count + CNT_W'(1);
        end
        if (write_index == IDX_W'(AVG_WINDOW - 1)) begin
          write_index <= '0;
        end else begin
          write_index <= write_index + IDX_W'(1);
        end
        on_time_accum <= '0;
        window_start  <= time_now;
      end
      if (cmd.avg_save) begin
        avg_duty <= div_q;
      end
    end
  end

  // Input latch, divider and result register carry payload only.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      action_r  <= in_action;
      raw_r     <= in_raw_level;
      elapsed_r <= in_elapsed_ms;
    end
    if (cmd.prep) begin
      // Quotients of 100 and above all clamp, so the division only has to find 7 bits.
      div_rem <= NUM_W'(on_time_accum) * NUM_W'(DUTY_MAX);
      div_ds  <= DS_W'(span_nz) << (DIV_STEPS - 1);
      div_q   <= '0;
      sat     <= (on_time_accum >= span_nz);
    end else if (cmd.avg_load) begin
      div_rem <= NUM_W'(duty_sum);
      div_ds  <= DS_W'(entry_count) << (DIV_STEPS - 1);
      div_q   <= '0;
    end else if (cmd.div_step) begin
      if (div_ge) begin
        div_rem <= div_rem - NUM_W'(div_ds);
      end
      div_q  <= {div_q[DUTY_W-2:0], div_ge};
      div_ds <= div_ds >> 1;
    end
    if (cmd.out_load) begin
      compressor_on <= deb_state;
      cycle_total   <= cycle_counter;
      window_duty   <= last_duty;
      average_duty  <= avg_duty;
      window_closed <= action_r;
    end
  end

endmodule

// ===== hw/rtl/debounced_duty_cycle_meter.sv =====
// A sample-only word goes from the sample state straight to the output state; a new word is
// taken only after the result is loaded. A window-closing word also runs a shared
// 7-step restoring divider, once for the window duty and once for the average.
// A waiting result does not block acceptance of the next word.
// Reset clears all time, debounce, count and sum state and sets the debounce time to 100 ms;
// the duty ring is not cleared, an entry is only read back after it has been written.
module debounced_duty_cycle_meter import ddcm_pkg::*; (
  input logic          clk,
  input logic          rst,
  ddcm_in_if.sink      in_ch,
  ddcm_out_if.source   out_ch,
  ddcm_cfg_if.sink     cfg_ch
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ch.ready = 1'b1;

  ddcm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .status    (status),
    .cmd       (cmd),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready)
  );

  ddcm_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .in_action     (in_ch.action),
    .in_raw_level  (in_ch.raw_level),
    .in_elapsed_ms (in_ch.elapsed_ms),
    .cfg_we        (cfg_ch.valid && cfg_ch.ready),
    .cfg_data      (cfg_ch.data),
    .compressor_on (out_ch.compressor_on),
    .cycle_total   (out_ch.cycle_total),
    .window_duty   (out_ch.window_duty),
    .average_duty  (out_ch.average_duty),
    .window_closed (out_ch.window_closed)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken again before the previous word finished");

  a_div_not_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> !in_ch.ready)
    else $error("divider stepping while the block is idle");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_ch.valid)
    else $error("result load did not raise valid");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.average_duty <= DUTY_W'(DUTY_MAX)) &&
                     (out_ch.window_duty <= DUTY_W'(DUTY_MAX)))
    else $error("duty above 100 percent");

endmodule
